FILE: rtl/imu_tilt_pkg.sv
package imu_tilt_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int RUN_STEPS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(RUN_STEPS + 1);
    localparam int CORDIC_W     = 37;
    localparam int ANG_W        = 28;
    localparam int ANG_MAX      = 46080;

    // gyro scale: floor(n * 250000 / 57295) == (n * RATE_RECIP) >> RATE_SHIFT, n <= 32768
    localparam int          RATE_SHIFT = 31;
    localparam logic [33:0] RATE_RECIP = 34'd9370292557;

    localparam logic [1:0] CFG_ACCEL_RANGE   = 2'd0;
    localparam logic [1:0] CFG_GYRO_RANGE    = 2'd1;
    localparam logic [1:0] CFG_BLEND_WEIGHT  = 2'd2;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RATE,
        ST_CORDIC,
        ST_PRED,
        ST_BLEND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_lane_ctl;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 28'd2949120;
            5'd1:  v = 28'd1740967;
            5'd2:  v = 28'd919879;
            5'd3:  v = 28'd466945;
            5'd4:  v = 28'd234379;
            5'd5:  v = 28'd117304;
            5'd6:  v = 28'd58666;
            5'd7:  v = 28'd29335;
            5'd8:  v = 28'd14668;
            5'd9:  v = 28'd7334;
            5'd10: v = 28'd3667;
            5'd11: v = 28'd1833;
            5'd12: v = 28'd917;
            5'd13: v = 28'd458;
            5'd14: v = 28'd229;
            5'd15: v = 28'd115;
            5'd16: v = 28'd57;
            5'd17: v = 28'd29;
            5'd18: v = 28'd14;
            5'd19: v = 28'd7;
            5'd20: v = 28'd4;
            5'd21: v = 28'd2;
            5'd22: v = 28'd1;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] sat_ang(input logic signed [47:0] v);
        logic signed [16:0] r;
        if (v > 48'sd46080) begin
            r = 17'sd46080;
        end else if (v < -48'sd46080) begin
            r = -17'sd46080;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/imu_tilt_lane.sv
// One CORDIC vectoring lane: atan2(num, den) in degrees Q8, one step a cycle.
module imu_tilt_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [14:0]  i_num,
    input  logic signed [14:0]  i_den,
    output logic                o_done,
    output logic signed [16:0]  o_angle
);
    localparam int W  = imu_tilt_pkg::CORDIC_W;
    localparam int AW = imu_tilt_pkg::ANG_W;
    localparam int SW = imu_tilt_pkg::STEP_W;

    logic                                r_busy;
    logic [SW-1:0]                       r_step;
    logic signed [W-1:0]                 r_x, r_y;
    logic signed [AW-1:0]                r_a;
    logic                                r_zero;
    logic signed [W-1:0]                 w_x0, w_y0, w_dx, w_dy;
    logic signed [AW-1:0]                w_a0, w_ar;

    always_comb begin
        logic signed [W-1:0] sx, sy;
        sx = {{(W-31){i_den[14]}}, i_den, 16'd0};
        sy = {{(W-31){i_num[14]}}, i_num, 16'd0};
        w_x0 = sx;
        w_y0 = sy;
        w_a0 = '0;
        if (i_den < 0) begin
            if (i_num >= 0) begin
                w_x0 = sy;
                w_y0 = -sx;
                w_a0 = AW'(90 * 65536);
            end else begin
                w_x0 = -sy;
                w_y0 = sx;
                w_a0 = -AW'(90 * 65536);
            end
        end
    end

    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;
    assign w_ar = (r_a + AW'(128)) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= w_x0;
                r_y    <= w_y0;
                r_a    <= w_a0;
                r_zero <= (i_num == 0) && (i_den == 0);
            end else if (r_busy) begin
                if (r_step == SW'(imu_tilt_pkg::RUN_STEPS)) begin
                    r_busy  <= 1'b0;
                    o_done  <= 1'b1;
                    o_angle <= r_zero ? '0
                             : imu_tilt_pkg::sat_ang(48'(w_ar));
                end else begin
                    if (r_y > 0) begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_a <= r_a + imu_tilt_pkg::atan_entry(5'(r_step));
                    end else begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_a <= r_a - imu_tilt_pkg::atan_entry(5'(r_step));
                    end
                    r_step <= r_step + SW'(1);
                end
            end
        end
    end
endmodule

FILE: rtl/imu_tilt_blend.sv
// Merge stage: gyro prediction and weighted blend for one angle, sequenced.
module imu_tilt_blend (
    input  logic                i_clk,
    input  logic                i_phase,   // 0: prediction, 1: blend
    input  logic                i_en,
    input  logic signed [16:0]  i_old,
    input  logic signed [16:0]  i_acc,
    input  logic signed [18:0]  i_rate,
    input  logic [16:0]         i_weight,
    input  logic [24:0]         i_period,
    output logic signed [16:0]  o_angle
);
    logic signed [44:0] w_prod;
    logic signed [19:0] r_pred;
    logic signed [19:0] w_inc;
    logic signed [50:0] w_sum;

    assign w_prod = 45'(i_rate * $signed({1'b0, i_period}));
    assign w_inc = 20'((w_prod + 45'sd134217728) >>> 28);
    assign w_sum = 51'($signed({1'b0, i_weight}) * i_acc)
                 + 51'($signed({1'b0, 17'(18'd65536 - 18'(i_weight))}) * r_pred)
                 + 51'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_phase) begin
                r_pred <= 20'(i_old) + w_inc;
            end else begin
                o_angle <= imu_tilt_pkg::sat_ang(48'(w_sum >>> 16));
            end
        end
    end
endmodule

FILE: rtl/imu_tilt_complementary_filter.sv
// A request passes through ST_SCALE, ST_RATE, ST_CORDIC, ST_PRED, ST_BLEND and ST_OUT.
// One item is in flight at a time, as a request is taken only in ST_IDLE;
//   the pace is set by the sixteen-step CORDIC lanes that run pitch and
//   roll side by side.
// The result register frees the input side while a result waits.
// Reset (synchronous, active low): registers to defaults, angles to zero.
module imu_tilt_complementary_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // raw_accel_x,y,z, raw_gyro_x,y,z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [135:0] m_axis_tdata,  // accel_x/y/z_mg, rate_x/y/z, pitch_out, roll_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    imu_tilt_pkg::t_state r_state, n_state;

    logic [1:0]  r_acc_rng;
    logic [2:0]  r_gyr_rng;
    logic [16:0] r_weight;
    logic [24:0] r_period;
    logic signed [16:0] r_pitch, r_roll;
    logic [95:0] r_in;
    logic signed [14:0] r_acc [3];
    logic signed [18:0] r_rate [3];
    logic        r_pdone, r_rdone;
    logic signed [16:0] w_pacc, w_racc, w_pnew, w_rnew;
    logic        w_pdone, w_rdone;
    imu_tilt_pkg::t_lane_ctl w_ctl;
    logic        r_ovalid;
    logic [135:0] r_odata;
    logic        w_take;
    logic        w_out_free;

    // gyro rate: |count| * 250000 / 57295 by reciprocal multiply, then >> range
    logic [17:0] r_gmag [3];
    logic [2:0]  r_gneg;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == imu_tilt_pkg::ST_IDLE);
    assign w_take = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_ctl.start = (r_state == imu_tilt_pkg::ST_RATE);
    assign w_ctl.done  = r_pdone && r_rdone;

    always_comb begin
        n_state = r_state;
        case (r_state)
            imu_tilt_pkg::ST_IDLE:   if (w_take) n_state = imu_tilt_pkg::ST_SCALE;
            imu_tilt_pkg::ST_SCALE:  n_state = imu_tilt_pkg::ST_RATE;
            imu_tilt_pkg::ST_RATE:   n_state = imu_tilt_pkg::ST_CORDIC;
            imu_tilt_pkg::ST_CORDIC: if (w_ctl.done) n_state = imu_tilt_pkg::ST_PRED;
            imu_tilt_pkg::ST_PRED:   n_state = imu_tilt_pkg::ST_BLEND;
            imu_tilt_pkg::ST_BLEND:  n_state = imu_tilt_pkg::ST_OUT;
            imu_tilt_pkg::ST_OUT:    if (w_out_free) n_state = imu_tilt_pkg::ST_IDLE;
            default:                 n_state = imu_tilt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imu_tilt_pkg::ST_IDLE;
            r_acc_rng <= 2'd1;
            r_gyr_rng <= 3'd1;
            r_weight <= 17'd2621;
            r_period <= 25'd16777;
            r_pitch <= '0;
            r_roll <= '0;
            r_ovalid <= 1'b0;
            r_pdone <= 1'b0;
            r_rdone <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    imu_tilt_pkg::CFG_ACCEL_RANGE:   r_acc_rng <= i_cfg_data[1:0];
                    imu_tilt_pkg::CFG_GYRO_RANGE:    r_gyr_rng <= i_cfg_data[2:0];
                    imu_tilt_pkg::CFG_BLEND_WEIGHT:
                        r_weight <= (i_cfg_data[16:0] > 17'd65536) ? 17'd65536
                                                                   : i_cfg_data[16:0];
                    imu_tilt_pkg::CFG_SAMPLE_PERIOD:
                        r_period <= (i_cfg_data[24:0] > 25'd16777216) ? 25'd16777216
                                                                      : i_cfg_data[24:0];
                    default: ;
                endcase
            end
            if (w_ctl.start) begin
                r_pdone <= 1'b0;
                r_rdone <= 1'b0;
            end else begin
                if (w_pdone) r_pdone <= 1'b1;
                if (w_rdone) r_rdone <= 1'b1;
            end
            if (r_state == imu_tilt_pkg::ST_OUT && w_out_free) begin
                r_pitch <= w_pnew;
                r_roll  <= w_rnew;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] prod;
        logic [15:0] gabs;
        logic [49:0] gprod;
        logic [18:0] rmag;
        if (w_take) r_in <= s_axis_tdata;
        if (r_state == imu_tilt_pkg::ST_SCALE) begin
            for (int k = 0; k < 3; k++) begin
                prod = 32'($signed(r_in[16*k +: 16]))
                     * 32'(15'd16000 >> r_acc_rng);
                r_acc[k] <= 15'((prod < 0) ? -((-prod) >>> 15) : (prod >>> 15));
                gabs = r_in[48 + 16*k + 15] ? (~r_in[48 + 16*k +: 16] + 16'd1)
                                            : r_in[48 + 16*k +: 16];
                gprod = 50'(gabs) * 50'(imu_tilt_pkg::RATE_RECIP);
                r_gmag[k] <= gprod[imu_tilt_pkg::RATE_SHIFT +: 18];
                r_gneg[k] <= r_in[48 + 16*k + 15];
            end
        end
        if (r_state == imu_tilt_pkg::ST_RATE) begin
            for (int k = 0; k < 3; k++) begin
                rmag = 19'(r_gmag[k] >> r_gyr_rng);
                r_rate[k] <= r_gneg[k] ? -$signed(rmag) : $signed(rmag);
            end
        end
        if (r_state == imu_tilt_pkg::ST_OUT && w_out_free) begin
            r_odata <= {w_rnew, w_pnew, r_rate[2], r_rate[1], r_rate[0],
                        r_acc[2], r_acc[1], r_acc[0]};
        end
    end

    imu_tilt_lane u_lane_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ctl.start),
        .i_num(r_acc[1]), .i_den(r_acc[2]), .o_done(w_pdone), .o_angle(w_pacc)
    );
    imu_tilt_lane u_lane_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ctl.start),
        .i_num(r_acc[0]), .i_den(r_acc[2]), .o_done(w_rdone), .o_angle(w_racc)
    );

    imu_tilt_blend u_blend_pitch (
        .i_clk(i_clk), .i_phase(r_state == imu_tilt_pkg::ST_BLEND),
        .i_en(r_state == imu_tilt_pkg::ST_PRED || r_state == imu_tilt_pkg::ST_BLEND),
        .i_old(r_pitch), .i_acc(w_pacc), .i_rate(r_rate[0]),
        .i_weight(r_weight), .i_period(r_period), .o_angle(w_pnew)
    );
    imu_tilt_blend u_blend_roll (
        .i_clk(i_clk), .i_phase(r_state == imu_tilt_pkg::ST_BLEND),
        .i_en(r_state == imu_tilt_pkg::ST_PRED || r_state == imu_tilt_pkg::ST_BLEND),
        .i_old(r_roll), .i_acc(w_racc), .i_rate(r_rate[1]),
        .i_weight(r_weight), .i_period(r_period), .o_angle(w_rnew)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

FILE: rtl/imu_tilt_checker.sv
module imu_tilt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken during work");
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[118:102]) <= 17'sd46080
                        && $signed(m_axis_tdata[118:102]) >= -17'sd46080))
        else $error("pitch out of range");
    a_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[135:119]) <= 17'sd46080
                        && $signed(m_axis_tdata[135:119]) >= -17'sd46080))
        else $error("roll out of range");
endmodule

bind imu_tilt_complementary_filter imu_tilt_checker u_chk (.*);

FILE: tb/imu_tilt_complementary_filter_tb.sv
module imu_tilt_complementary_filter_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } t_sample;

    typedef struct {
        logic signed [14:0] ax_mg, ay_mg, az_mg;
        logic signed [18:0] rx, ry, rz;
        logic signed [16:0] pitch, roll;
    } t_tilt;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    imu_tilt_complementary_filter dut (.*);

    // predictor state
    int unsigned pm_accel_range, pm_gyro_range, pm_weight, pm_period;
    longint pm_pitch, pm_roll;

    t_sample pending_samples[$];
    t_tilt expected_tilts[$];
    int errors = 0;
    int idle_cycles;
    bit hold_off;
    int hold_count;
    bit pause_sender;
    int burst_left, gap_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > imu_tilt_pkg::ANG_MAX) return imu_tilt_pkg::ANG_MAX;
        if (v < -imu_tilt_pkg::ANG_MAX) return -imu_tilt_pkg::ANG_MAX;
        return v;
    endfunction

    function automatic longint atan_q16(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint tilt_deg_q8(longint num, longint den);
        longint x, y, a, t, dx, dy;
        a = 0;
        if (num == 0 && den == 0) return 0;
        x = den * 65536;
        y = num * 65536;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; a = 90 * 65536;
            end else begin
                x = -y; y = t; a = -90 * 65536;
            end
        end
        for (int i = 0; i < imu_tilt_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; a += atan_q16(i);
            end else begin
                x -= dx; y += dy; a -= atan_q16(i);
            end
        end
        return clamp_angle(floor_shr(a + 128, 8));
    endfunction

    function automatic longint blend_angle(longint prev, longint acc, longint rate);
        longint w, p, pred;
        w = (pm_weight > 65536) ? 65536 : pm_weight;
        p = (pm_period > 16777216) ? 16777216 : pm_period;
        pred = prev + floor_shr(rate * p + (longint'(1) << 27), 28);
        return clamp_angle(floor_shr(w * acc + (65536 - w) * pred + 32768, 16));
    endfunction

    function automatic t_tilt predict_tilt(t_sample s);
        t_tilt r;
        longint fs, gden, a[3], g[3];
        fs = 16000 >> pm_accel_range;
        gden = longint'(57295) << pm_gyro_range;
        // SystemVerilog division truncates toward zero, as required
        a[0] = longint'(s.ax) * fs / 32768;
        a[1] = longint'(s.ay) * fs / 32768;
        a[2] = longint'(s.az) * fs / 32768;
        g[0] = longint'(s.gx) * 250000 / gden;
        g[1] = longint'(s.gy) * 250000 / gden;
        g[2] = longint'(s.gz) * 250000 / gden;
        pm_pitch = blend_angle(pm_pitch, tilt_deg_q8(a[1], a[2]), g[0]);
        pm_roll = blend_angle(pm_roll, tilt_deg_q8(a[0], a[2]), g[1]);
        r.ax_mg = 15'(a[0]); r.ay_mg = 15'(a[1]); r.az_mg = 15'(a[2]);
        r.rx = 19'(g[0]); r.ry = 19'(g[1]); r.rz = 19'(g[2]);
        r.pitch = 17'(pm_pitch); r.roll = 17'(pm_roll);
        return r;
    endfunction

    function automatic t_sample rand_sample(int mode);
        t_sample s;
        s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
        s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
        if (mode == 1) begin
            // mostly small tilt with gravity near z
            s.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.az = $urandom_range(0, 1) ? 16'sd4096 : -16'sd4096;
            s.gx = 16'($signed($urandom_range(0, 2000)) - 1000);
            s.gy = 16'($signed($urandom_range(0, 2000)) - 1000);
        end
        return s;
    endfunction

    function automatic t_sample mk(int ax, int ay, int az, int gx, int gy, int gz);
        t_sample s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
        return s;
    endfunction

    // driver: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_tilts.push_back(predict_tilt(pending_samples.pop_front()));
            end
            if (pending_samples.size() > 0 && !pause_sender && gap_left == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_samples[0].gz, pending_samples[0].gy,
                                 pending_samples[0].gx, pending_samples[0].az,
                                 pending_samples[0].ay, pending_samples[0].ax};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // receiver stalls and result check
    always @(posedge i_clk) begin
        t_tilt exp_t, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ax_mg = m_axis_tdata[14:0];
                got.ay_mg = m_axis_tdata[29:15];
                got.az_mg = m_axis_tdata[44:30];
                got.rx = m_axis_tdata[63:45];
                got.ry = m_axis_tdata[82:64];
                got.rz = m_axis_tdata[101:83];
                got.pitch = m_axis_tdata[118:102];
                got.roll = m_axis_tdata[135:119];
                if (expected_tilts.size() == 0) begin
                    $error("unexpected result");
                    errors++;
                end else begin
                    exp_t = expected_tilts.pop_front();
                    if (got.ax_mg !== exp_t.ax_mg) begin
                        $error("accel_x_mg exp %0d got %0d", exp_t.ax_mg, got.ax_mg); errors++;
                    end
                    if (got.ay_mg !== exp_t.ay_mg) begin
                        $error("accel_y_mg exp %0d got %0d", exp_t.ay_mg, got.ay_mg); errors++;
                    end
                    if (got.az_mg !== exp_t.az_mg) begin
                        $error("accel_z_mg exp %0d got %0d", exp_t.az_mg, got.az_mg); errors++;
                    end
                    if (got.rx !== exp_t.rx) begin
                        $error("rate_x exp %0d got %0d", exp_t.rx, got.rx); errors++;
                    end
                    if (got.ry !== exp_t.ry) begin
                        $error("rate_y exp %0d got %0d", exp_t.ry, got.ry); errors++;
                    end
                    if (got.rz !== exp_t.rz) begin
                        $error("rate_z exp %0d got %0d", exp_t.rz, got.rz); errors++;
                    end
                    if (got.pitch !== exp_t.pitch) begin
                        $error("pitch_out exp %0d got %0d", exp_t.pitch, got.pitch); errors++;
                    end
                    if (got.roll !== exp_t.roll) begin
                        $error("roll_out exp %0d got %0d", exp_t.roll, got.roll); errors++;
                    end
                end
            end
            if (hold_off && hold_count < 400) begin
                m_axis_tready <= 1'b0;
                hold_count <= hold_count + 1;
            end else begin
                if (!hold_off) hold_count <= 0;
                // own stall pattern: ready is drawn at random every clock, mostly high
                m_axis_tready <= ($urandom_range(0, 7) < 5) || (($urandom & 255) < 40);
            end
        end
    end

    // watchdog on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_tilts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            imu_tilt_pkg::CFG_ACCEL_RANGE:   pm_accel_range = value & 3;
            imu_tilt_pkg::CFG_GYRO_RANGE:    pm_gyro_range = value & 7;
            imu_tilt_pkg::CFG_BLEND_WEIGHT:  pm_weight = value & 32'h1FFFF;
            imu_tilt_pkg::CFG_SAMPLE_PERIOD: pm_period = value & 32'h1FFFFFF;
            default: ;
        endcase
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            pending_samples.push_back(rand_sample(($urandom_range(0, 9) < 6) ? 1 : 0));
        wait_drained();
    endtask

    initial begin
        hold_off = 0;
        pause_sender = 0;
        pm_accel_range = 1; pm_gyro_range = 1; pm_weight = 2621; pm_period = 16777;
        pm_pitch = 0; pm_roll = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero vector, negative z both sides, axes
        pending_samples.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_samples.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
        pending_samples.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_samples.push_back(mk(1000, 1000, -4096, 0, 0, 0));
        pending_samples.push_back(mk(-1000, -1000, -4096, 0, 0, 0));
        pending_samples.push_back(mk(0, 0, -4096, 100, -100, 5));
        pending_samples.push_back(mk(4096, -4096, 0, -1, 1, -1));
        pending_samples.push_back(mk(1, -1, 1, 1, -1, 1));
        pending_samples.push_back(mk(-32768, 32767, 0, 32767, -32768, 0));
        pending_samples.push_back(mk(0, 0, 32767, 0, 0, 0));
        wait_drained();

        // extreme weights and periods, over-range values clamp
        write_reg(imu_tilt_pkg::CFG_ACCEL_RANGE, 3);
        write_reg(imu_tilt_pkg::CFG_GYRO_RANGE, 7);
        write_reg(imu_tilt_pkg::CFG_BLEND_WEIGHT, 0);
        write_reg(imu_tilt_pkg::CFG_SAMPLE_PERIOD, 16777216);
        pending_samples.push_back(mk(32767, -32768, 100, 32767, 32767, -32768));
        pending_samples.push_back(mk(-32768, 32767, -100, -32768, -32768, 32767));
        pending_samples.push_back(mk(32767, 32767, 1, 32767, 32767, 32767));
        random_phase(150);

        write_reg(imu_tilt_pkg::CFG_BLEND_WEIGHT, 131071);
        write_reg(imu_tilt_pkg::CFG_SAMPLE_PERIOD, 33554431);
        write_reg(imu_tilt_pkg::CFG_ACCEL_RANGE, 0);
        write_reg(imu_tilt_pkg::CFG_GYRO_RANGE, 0);
        pending_samples.push_back(mk(12345, -12345, -1, 777, -777, 0));
        random_phase(150);

        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        for (int i = 0; i < 20; i++) pending_samples.push_back(rand_sample(1));
        repeat (400) @(posedge i_clk);
        hold_off = 0;
        wait_drained();

        write_reg(imu_tilt_pkg::CFG_BLEND_WEIGHT, 65536);
        write_reg(imu_tilt_pkg::CFG_SAMPLE_PERIOD, 0);
        write_reg(imu_tilt_pkg::CFG_ACCEL_RANGE, 2);
        write_reg(imu_tilt_pkg::CFG_GYRO_RANGE, 3);
        random_phase(200);

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(imu_tilt_pkg::CFG_ACCEL_RANGE, $urandom_range(0, 3));
            write_reg(imu_tilt_pkg::CFG_GYRO_RANGE, $urandom_range(0, 7));
            write_reg(imu_tilt_pkg::CFG_BLEND_WEIGHT,
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 8000));
            write_reg(imu_tilt_pkg::CFG_SAMPLE_PERIOD,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000));
            // sender pause mid-stream: hold until all results are in, then resume
            for (int i = 0; i < 30; i++) pending_samples.push_back(rand_sample(1));
            while (pending_samples.size() > 15) @(posedge i_clk);
            pause_sender = 1;
            while (s_axis_tvalid || expected_tilts.size() > 0) @(posedge i_clk);
            pause_sender = 0;
            random_phase(150);
        end

        write_reg(imu_tilt_pkg::CFG_ACCEL_RANGE, 1);
        write_reg(imu_tilt_pkg::CFG_GYRO_RANGE, 1);
        write_reg(imu_tilt_pkg::CFG_BLEND_WEIGHT, 2621);
        write_reg(imu_tilt_pkg::CFG_SAMPLE_PERIOD, 16777);
        random_phase(100);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/imu_tilt_pkg.sv
rtl/imu_tilt_lane.sv
rtl/imu_tilt_blend.sv
rtl/imu_tilt_complementary_filter.sv
rtl/imu_tilt_checker.sv
tb/imu_tilt_complementary_filter_tb.sv
